FILE: hdl/itrd_pkg.sv
// Shared constants, command/status types and the digit character lookup
// for the integer to radix digits block. No dependencies.
package itrd_pkg;

  localparam int VALUE_BITS = 31;
  localparam int MAX_DIGITS = 31;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int BIT_W      = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] NUM_DIGIT_CHARS = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] NUM_DECIMAL = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(8'h61);

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic emit;
    logic emit_bad;
  } cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic div_done;
    logic more;
    logic last;
  } sts_t;

  // Map a digit index onto '0'-'9', 'a'-'z'; anything else gives zero.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] idx);
    logic [CHAR_W-1:0] ch;
    if (idx < NUM_DECIMAL) begin
      ch = CHAR_ZERO + CHAR_W'(idx);
    end else if (idx < NUM_DIGIT_CHARS) begin
      ch = CHAR_A + CHAR_W'(idx - NUM_DECIMAL);
    end else begin
      ch = '0;
    end
    return ch;
  endfunction

endpackage

FILE: hdl/integer_to_radix_digits_core.sv
// Top level of the integer to radix digits converter.
// Instantiates itrd_ctrl and itrd_dpath; depends on itrd_pkg.
//
// An item is taken when start is high and busy is low. Each digit is
// worked out by a restoring divider that retires one quotient bit a cycle
// and stored in the digit memory; once all digits are stored, each digit is
// read back from the digit memory and shown, and busy stays high until the
// final digit is emitted. Digits come most significant first, one beat each,
// with out_strobe high for exactly one cycle and out_is_last on the final
// beat; the receiver must take every beat as it appears. A radix outside
// 2..36 gives a single beat flagged by out_bad_radix in the cycle after the
// item is taken, and busy stays low.
module integer_to_radix_digits_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [itrd_pkg::VALUE_BITS-1:0]  in_value,
  input  logic [itrd_pkg::RADIX_W-1:0]     in_radix,
  output logic                             out_strobe,
  output logic [itrd_pkg::CHAR_W-1:0]      out_digit_char,
  output logic                             out_is_last,
  output logic                             out_bad_radix
);

  itrd_pkg::cmd_t cmd;
  itrd_pkg::sts_t sts;

  itrd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  itrd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .cmd            (cmd),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_is_last    (out_is_last),
    .out_bad_radix  (out_bad_radix)
  );

endmodule

FILE: hdl/itrd_ctrl.sv
// Sequencing state machine: divide, store, read back and emit digits.
// Depends on itrd_pkg for command and status types.
module itrd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  itrd_pkg::sts_t sts,
  output itrd_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.radix_bad) begin
            cmd.emit_bad = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = sts.more ? ST_DIV : ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.last ? ST_IDLE : ST_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: hdl/itrd_dpath.sv
// Datapath: one-bit-per-cycle restoring divider, digit memory and
// registered result outputs. Depends on itrd_pkg.
module itrd_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [itrd_pkg::VALUE_BITS-1:0]  in_value,
  input  logic [itrd_pkg::RADIX_W-1:0]     in_radix,
  input  itrd_pkg::cmd_t                   cmd,
  output itrd_pkg::sts_t                   sts,
  output logic                             out_strobe,
  output logic [itrd_pkg::CHAR_W-1:0]      out_digit_char,
  output logic                             out_is_last,
  output logic                             out_bad_radix
);

  logic [itrd_pkg::VALUE_BITS-1:0] quo_r;
  logic [itrd_pkg::RADIX_W-1:0]    rem_r;
  logic [itrd_pkg::RADIX_W-1:0]    radix_r;
  logic [itrd_pkg::BIT_W-1:0]      bit_cnt_r;
  logic [itrd_pkg::CNT_W-1:0]      dig_cnt_r;
  logic [itrd_pkg::RADIX_W-1:0]    rd_data_r;
  logic [itrd_pkg::RADIX_W-1:0]    mem [itrd_pkg::MAX_DIGITS];
  logic                            strobe_r;
  logic [itrd_pkg::CHAR_W-1:0]     char_r;
  logic                            last_r;
  logic                            bad_r;

  logic [itrd_pkg::RADIX_W:0]      shifted;
  logic                            ge;
  logic [itrd_pkg::RADIX_W-1:0]    rem_nxt;
  logic [itrd_pkg::CNT_W-1:0]      dig_cnt_m1;

  assign shifted    = {rem_r, quo_r[itrd_pkg::VALUE_BITS-1]};
  assign ge         = (shifted >= {1'b0, radix_r});
  assign rem_nxt    = ge ? itrd_pkg::RADIX_W'(shifted - {1'b0, radix_r})
                         : shifted[itrd_pkg::RADIX_W-1:0];
  assign dig_cnt_m1 = dig_cnt_r - itrd_pkg::CNT_W'(1);

  assign sts.radix_bad = (in_radix < itrd_pkg::RADIX_MIN) || (in_radix > itrd_pkg::RADIX_MAX);
  assign sts.div_done  = (bit_cnt_r == itrd_pkg::BIT_W'(itrd_pkg::VALUE_BITS - 1));
  assign sts.more      = (quo_r != '0) &&
                         (dig_cnt_r < itrd_pkg::CNT_W'(itrd_pkg::MAX_DIGITS - 1));
  assign sts.last      = (dig_cnt_r == itrd_pkg::CNT_W'(1));

  // control counters and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= cmd.emit | cmd.emit_bad;
      if (cmd.load) begin
        bit_cnt_r <= '0;
        dig_cnt_r <= '0;
      end else if (cmd.div_step) begin
        bit_cnt_r <= bit_cnt_r + itrd_pkg::BIT_W'(1);
      end else if (cmd.store) begin
        bit_cnt_r <= '0;
        dig_cnt_r <= dig_cnt_r + itrd_pkg::CNT_W'(1);
      end else if (cmd.emit) begin
        dig_cnt_r <= dig_cnt_m1;
      end
    end
  end

  // divider payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r   <= in_value;
      rem_r   <= '0;
      radix_r <= in_radix;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[itrd_pkg::VALUE_BITS-2:0], ge};
      rem_r <= rem_nxt;
    end else if (cmd.store) begin
      rem_r <= '0;
    end
  end

  // digit memory, least significant first
  always_ff @(posedge clk) begin
    if (cmd.store) mem[dig_cnt_r[itrd_pkg::IDX_W-1:0]] <= rem_r;
    if (cmd.rd) rd_data_r <= mem[dig_cnt_m1[itrd_pkg::IDX_W-1:0]];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.emit_bad) begin
      char_r <= '0;
      last_r <= 1'b1;
      bad_r  <= 1'b1;
    end else if (cmd.emit) begin
      char_r <= itrd_pkg::digit_to_char(rd_data_r);
      last_r <= sts.last;
      bad_r  <= 1'b0;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_digit_char = char_r;
  assign out_is_last    = last_r;
  assign out_bad_radix  = bad_r;

endmodule

FILE: hdl/itrd_checker.sv
// Port-level checks for integer_to_radix_digits_core, bound to the top level.
// Depends on itrd_pkg for widths.
module itrd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic [itrd_pkg::VALUE_BITS-1:0]  in_value,
  input logic [itrd_pkg::RADIX_W-1:0]     in_radix,
  input logic                             out_strobe,
  input logic [itrd_pkg::CHAR_W-1:0]      out_digit_char,
  input logic                             out_is_last,
  input logic                             out_bad_radix
);

  logic bad_in;
  assign bad_in = (in_radix < itrd_pkg::RADIX_MIN) || (in_radix > itrd_pkg::RADIX_MAX);

  a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && bad_in |=> out_strobe && out_bad_radix && out_is_last)
    else $error("bad radix beat missing");

  a_good_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !bad_in |=> busy)
    else $error("accepted item did not raise busy");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_bad_radix |-> out_digit_char == '0 && out_is_last)
    else $error("bad radix beat carries a character");

  a_digit_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_bad_radix && !out_is_last |=> !out_strobe && busy)
    else $error("digit beats not spaced by read-back");

endmodule

bind integer_to_radix_digits_core itrd_checker u_chk (.*);

FILE: test/integer_to_radix_digits_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_to_radix_digits_core: directed and random
// conversions, digit beats predicted in-bench and checked in order.
// Depends on itrd_pkg and the core RTL only.
module integer_to_radix_digits_core_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int QUIET_CYCLES = 64;
  localparam int RANDOM_ITEMS = 100;
  localparam int DIGIT_SET_LEN = 36;
  localparam logic [8*DIGIT_SET_LEN-1:0] DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

  typedef struct {
    logic [itrd_pkg::VALUE_BITS-1:0] value;
    logic [itrd_pkg::RADIX_W-1:0]    radix;
  } conv_item_t;

  typedef struct {
    logic [itrd_pkg::CHAR_W-1:0] digit_char;
    logic                        is_last;
    logic                        bad_radix;
  } digit_beat_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [itrd_pkg::VALUE_BITS-1:0] in_value = '0;
  logic [itrd_pkg::RADIX_W-1:0]    in_radix = '0;
  logic                            out_strobe;
  logic [itrd_pkg::CHAR_W-1:0]     out_digit_char;
  logic                            out_is_last;
  logic                            out_bad_radix;

  conv_item_t  pending_items[$];
  digit_beat_t digit_beats[$];

  logic [itrd_pkg::RADIX_W-1:0]    digit_idx [itrd_pkg::MAX_DIGITS];
  int                              digit_total = 0;
  logic [itrd_pkg::VALUE_BITS-1:0] quotient_left = '0;

  int mismatch_count = 0;
  int items_taken = 0;
  int bad_items = 0;
  int beats_seen = 0;
  int longest_number = 0;
  int burst_left = 1;
  int gap_left = 0;
  int idle_cycles = 0;
  conv_item_t next_item;

  integer_to_radix_digits_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_is_last    (out_is_last),
    .out_bad_radix  (out_bad_radix)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic predict_digits(input logic [itrd_pkg::VALUE_BITS-1:0] value,
                                input logic [itrd_pkg::RADIX_W-1:0] radix);
    digit_beat_t                  beat;
    logic [itrd_pkg::RADIX_W-1:0] idx;
    if (radix < itrd_pkg::RADIX_MIN || radix > itrd_pkg::RADIX_MAX) begin
      beat.digit_char = '0;
      beat.is_last = 1'b1;
      beat.bad_radix = 1'b1;
      digit_beats.push_back(beat);
      bad_items++;
    end else begin
      quotient_left = value;
      digit_total = 0;
      if (quotient_left == '0) begin
        digit_idx[0] = '0;
        digit_total = 1;
      end else begin
        while (quotient_left != '0 && digit_total < itrd_pkg::MAX_DIGITS) begin
          digit_idx[digit_total] = itrd_pkg::RADIX_W'(
              quotient_left % itrd_pkg::VALUE_BITS'(radix));
          quotient_left = quotient_left / itrd_pkg::VALUE_BITS'(radix);
          digit_total++;
        end
      end
      if (digit_total > longest_number) longest_number = digit_total;
      for (int i = digit_total; i > 0; i--) begin
        idx = digit_idx[i-1];
        beat.digit_char = (idx < DIGIT_SET_LEN) ?
            itrd_pkg::CHAR_W'(DIGIT_SET[8*(DIGIT_SET_LEN-1-idx) +: 8]) : '0;
        beat.is_last = (i == 1);
        beat.bad_radix = 1'b0;
        digit_beats.push_back(beat);
      end
    end
  endtask

  function automatic void add_item(input logic [itrd_pkg::VALUE_BITS-1:0] value,
                                   input logic [itrd_pkg::RADIX_W-1:0] radix);
    conv_item_t item;
    item.value = value;
    item.radix = radix;
    pending_items.push_back(item);
  endfunction

  // Sender: bursts of items separated by random gaps; hold start while busy.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_digits(in_value, in_radix);
        items_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_value <= next_item.value;
          in_radix <= next_item.radix;
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      beats_seen++;
      if (digit_beats.size() == 0) begin
        $error("unexpected beat: digit_char %0h is_last %0b bad_radix %0b",
               out_digit_char, out_is_last, out_bad_radix);
        mismatch_count++;
      end else begin
        automatic digit_beat_t want = digit_beats.pop_front();
        if (out_digit_char !== want.digit_char) begin
          $error("digit_char: expected %0h, got %0h", want.digit_char, out_digit_char);
          mismatch_count++;
        end
        if (out_is_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, out_is_last);
          mismatch_count++;
        end
        if (out_bad_radix !== want.bad_radix) begin
          $error("bad_radix: expected %0b, got %0b", want.bad_radix, out_bad_radix);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("integer_to_radix_digits_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [itrd_pkg::VALUE_BITS-1:0] value;
    logic [itrd_pkg::RADIX_W-1:0]    radix;
    int                              shape;

    add_item('0, 6'd2);
    add_item('0, 6'd10);
    add_item('0, 6'd36);
    add_item('1, 6'd2);
    add_item('1, 6'd36);
    add_item('1, 6'd10);
    add_item('1, 6'd16);
    add_item(itrd_pkg::VALUE_BITS'(1), 6'd2);
    add_item(itrd_pkg::VALUE_BITS'(35), 6'd36);
    add_item(itrd_pkg::VALUE_BITS'(36), 6'd36);
    add_item(itrd_pkg::VALUE_BITS'(32'h5555_5555), 6'd2);
    add_item(itrd_pkg::VALUE_BITS'(32'h2AAA_AAAA), 6'd2);
    add_item(itrd_pkg::VALUE_BITS'(32'h0123_4567), 6'd8);
    add_item(itrd_pkg::VALUE_BITS'(1234567), 6'd3);
    add_item(itrd_pkg::VALUE_BITS'(9), 6'd10);
    add_item(itrd_pkg::VALUE_BITS'(12345), 6'd0);
    add_item('1, 6'd1);
    add_item('0, 6'd37);
    add_item(itrd_pkg::VALUE_BITS'(77), 6'd63);
    add_item('1, 6'd35);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        radix = ($urandom_range(0, 2) == 0) ?
            itrd_pkg::RADIX_W'($urandom_range(0, 1)) :
            itrd_pkg::RADIX_W'($urandom_range(37, 63));
      end else begin
        radix = itrd_pkg::RADIX_W'($urandom_range(2, 36));
      end
      shape = $urandom_range(0, 3);
      case (shape)
        0: value = itrd_pkg::VALUE_BITS'($urandom >> $urandom_range(1, 30));
        1: value = itrd_pkg::VALUE_BITS'($urandom_range(0, 40));
        default: value = itrd_pkg::VALUE_BITS'($urandom);
      endcase
      add_item(value, radix);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_items.size() != 0 || start || digit_beats.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);

    $display("ran %0d conversions, %0d with a bad radix; checked %0d digit beats",
             items_taken, bad_items, beats_seen);
    $display("longest number converted: %0d digits", longest_number);
    if (mismatch_count == 0 && digit_beats.size() == 0) begin
      $display("integer_to_radix_digits_core verification clean");
    end else begin
      $display("integer_to_radix_digits_core verification failed");
    end
    $finish;
  end

endmodule
